// ===== hdl/tpr_pkg.sv =====
// shared types and constants for the trapezoidal position ramp
`timescale 1ns / 1ps

package tpr_pkg;

    localparam int POS_W      = 32;
    localparam int SPD_OUT_W  = 17;
    localparam int LIM_W      = 16;
    localparam int DIST_W     = POS_W + 1;
    localparam int PROD_W     = POS_W + LIM_W;
    localparam int RAD_W      = PROD_W + 2;
    localparam int ROOT_STEPS = RAD_W / 2;
    localparam int ROOT_W     = ROOT_STEPS + 1;
    localparam int RAMP_W     = ROOT_W + 2;
    localparam int SPD_W      = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CNT_W      = $clog2(ROOT_STEPS);
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 56;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_POS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_NEG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_POS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_NEG = 2'd3;

    typedef struct packed {
        logic load;
        logic mul_sq;
        logic mul_d;
        logic sum;
        logic root_step;
        logic limit;
        logic select;
        logic out_load;
    } tpr_cmd_t;

    typedef struct packed {
        logic out_free;
    } tpr_status_t;

endpackage

// ===== hdl/tpr_ctrl.sv =====
// sequencer that steps the ramp datapath through one request
`timescale 1ns / 1ps

module tpr_ctrl
    import tpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  tpr_status_t status,
    output tpr_cmd_t    cmd
);

    typedef enum logic [2:0] {
        IDLE,
        MUL_SQ,
        MUL_D,
        SUM,
        ROOT,
        LIMIT,
        SELECT,
        WRITE
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            count_reg <= '0;
        end
        else
        begin
            case (state_reg)
                IDLE:
                begin
                    if (s_tvalid)
                        state_reg <= MUL_SQ;
                end
                MUL_SQ: state_reg <= MUL_D;
                MUL_D:  state_reg <= SUM;
                SUM:
                begin
                    state_reg <= ROOT;
                    count_reg <= '0;
                end
                ROOT:
                begin
                    if (count_reg == CNT_W'(ROOT_STEPS - 1))
                        state_reg <= LIMIT;
                    else
                        count_reg <= count_reg + 1'b1;
                end
                LIMIT:  state_reg <= SELECT;
                SELECT: state_reg <= WRITE;
                WRITE:
                begin
                    if (status.out_free)
                        state_reg <= IDLE;
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == IDLE);

    always_comb
    begin
        cmd           = '0;
        cmd.load      = (state_reg == IDLE) && s_tvalid;
        cmd.mul_sq    = (state_reg == MUL_SQ);
        cmd.mul_d     = (state_reg == MUL_D);
        cmd.sum       = (state_reg == SUM);
        cmd.root_step = (state_reg == ROOT);
        cmd.limit     = (state_reg == LIMIT);
        cmd.select    = (state_reg == SELECT);
        cmd.out_load  = (state_reg == WRITE) && status.out_free;
    end

`ifndef SYNTHESIS
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> cmd.mul_sq)
        else $error("accepted request did not start the multiply");

    a_root_length: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sum |-> ##(ROOT_STEPS + 1) cmd.limit)
        else $error("square root did not run its full step count");
`endif

endmodule

// ===== hdl/tpr_datapath.sv =====
// registers, braking root, speed clamps and output register of the ramp
`timescale 1ns / 1ps

module tpr_datapath
    import tpr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  tpr_cmd_t               cmd,
    output tpr_status_t            status,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [LIM_W-1:0]       cfg_data,
    input  logic [POS_W-1:0]       target_position,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [POS_W-1:0]       setpoint_position,
    output logic [SPD_OUT_W-1:0]   setpoint_speed
);

    logic [LIM_W-1:0]            spd_pos_reg;
    logic [LIM_W-1:0]            spd_neg_reg;
    logic [LIM_W-1:0]            acc_pos_reg;
    logic [LIM_W-1:0]            acc_neg_reg;

    logic signed [POS_W-1:0]     last_pos_reg;
    logic signed [SPD_OUT_W-1:0] last_speed_reg;

    logic signed [DIST_W-1:0]    d_reg;
    logic [2*LIM_W-1:0]          sq_reg;
    logic [PROD_W-1:0]           prod_reg;
    logic [RAD_W-1:0]            rad_reg;
    logic [RAD_W-1:0]            res_reg;
    logic [RAD_W-1:0]            bit_reg;
    logic signed [SPD_W-1:0]     hi_reg;
    logic signed [SPD_W-1:0]     lo_reg;

    logic                        m_tvalid_reg;
    logic [POS_W-1:0]            out_pos_reg;
    logic [SPD_OUT_W-1:0]        out_spd_reg;

    logic                        d_pos;
    logic                        d_neg;
    logic [DIST_W-1:0]           d_negated;
    logic [POS_W-1:0]            mag;
    logic [LIM_W-1:0]            a_sel;
    logic [RAD_W-1:0]            trial;
    logic [ROOT_W-1:0]           root;
    logic signed [RAMP_W-1:0]    ramp_p;
    logic signed [RAMP_W-1:0]    ramp_n;
    logic signed [SPD_W-1:0]     hi0;
    logic signed [SPD_W-1:0]     lo0;
    logic signed [SPD_W-1:0]     hi1;
    logic signed [SPD_W-1:0]     lo1;
    logic signed [SPD_W-1:0]     hi_next;
    logic signed [SPD_W-1:0]     lo_next;
    logic signed [SPD_W-1:0]     prev;
    logic signed [SPD_W-1:0]     ap_s;
    logic signed [SPD_W-1:0]     an_s;
    logic signed [SPD_W-1:0]     diff_h;
    logic signed [SPD_W-1:0]     diff_l;
    logic signed [DIST_W-1:0]    hi_ext;
    logic signed [DIST_W-1:0]    lo_ext;
    logic signed [SPD_OUT_W-1:0] speed;

    // distance sign and magnitude pick the braking side
    assign d_neg     = d_reg[DIST_W-1];
    assign d_pos     = !d_neg && (d_reg != '0);
    assign d_negated = DIST_W'(0) - d_reg;
    assign mag       = d_neg ? d_negated[POS_W-1:0] : d_reg[POS_W-1:0];
    assign a_sel     = d_neg ? acc_pos_reg : acc_neg_reg;

    assign trial = res_reg + bit_reg;
    assign root  = res_reg[ROOT_W-1:0];

    always_comb
    begin
        ramp_p = RAMP_W'({2'b00, root}) - RAMP_W'(acc_neg_reg >> 1);
        ramp_n = RAMP_W'(0) - RAMP_W'({2'b00, root}) - RAMP_W'(acc_pos_reg >> 1);
        hi0    = SPD_W'({4'b0000, spd_pos_reg});
        lo0    = SPD_W'(0) - SPD_W'({4'b0000, spd_neg_reg});
        prev   = SPD_W'(last_speed_reg);
        ap_s   = SPD_W'({4'b0000, acc_pos_reg});
        an_s   = SPD_W'({4'b0000, acc_neg_reg});

        hi1 = hi0;
        if (d_pos && (acc_neg_reg != '0) && (ramp_p < RAMP_W'(hi0)))
            hi1 = ramp_p[SPD_W-1:0];
        lo1 = lo0;
        if (d_neg && (acc_pos_reg != '0) && (ramp_n > RAMP_W'(lo0)))
            lo1 = ramp_n[SPD_W-1:0];

        diff_h  = hi1 - prev;
        hi_next = hi1;
        if (prev < hi1)
        begin
            if ((acc_pos_reg != '0) && (diff_h > ap_s))
                hi_next = prev + ap_s;
        end
        else if (prev > hi1)
        begin
            if ((acc_neg_reg != '0) && (diff_h < -an_s))
                hi_next = prev - an_s;
        end

        diff_l  = lo1 - prev;
        lo_next = lo1;
        if (prev > lo1)
        begin
            if ((acc_neg_reg != '0) && (diff_l < -an_s))
                lo_next = prev - an_s;
        end
        else if (prev < lo1)
        begin
            if ((acc_pos_reg != '0) && (diff_l > ap_s))
                lo_next = prev + ap_s;
        end
    end

    assign hi_ext = DIST_W'(hi_reg);
    assign lo_ext = DIST_W'(lo_reg);

    always_comb
    begin
        if (d_reg > hi_ext)
            speed = hi_reg[SPD_OUT_W-1:0];
        else if (d_reg < lo_ext)
            speed = lo_reg[SPD_OUT_W-1:0];
        else
            speed = d_reg[SPD_OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spd_pos_reg    <= '0;
            spd_neg_reg    <= '0;
            acc_pos_reg    <= '0;
            acc_neg_reg    <= '0;
            last_pos_reg   <= '0;
            last_speed_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SPEED_POS: spd_pos_reg <= cfg_data;
                    CFG_SPEED_NEG: spd_neg_reg <= cfg_data;
                    CFG_ACCEL_POS: acc_pos_reg <= cfg_data;
                    CFG_ACCEL_NEG: acc_neg_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.select)
            begin
                last_pos_reg   <= last_pos_reg + POS_W'(speed);
                last_speed_reg <= speed;
            end
            if (cmd.out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            d_reg <= DIST_W'($signed(target_position)) - DIST_W'(last_pos_reg);
        if (cmd.mul_sq)
            sq_reg <= (2*LIM_W)'(a_sel) * (2*LIM_W)'(a_sel);
        if (cmd.mul_d)
            prod_reg <= PROD_W'(mag) * PROD_W'(a_sel);
        if (cmd.sum)
        begin
            rad_reg <= RAD_W'(sq_reg >> 2) + RAD_W'({prod_reg, 1'b0});
            res_reg <= '0;
            bit_reg <= RAD_W'(1) << (2 * (ROOT_STEPS - 1));
        end
        // one result bit per step, restoring square root
        if (cmd.root_step)
        begin
            if (rad_reg >= trial)
            begin
                rad_reg <= rad_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.limit)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
        if (cmd.out_load)
        begin
            out_pos_reg <= last_pos_reg;
            out_spd_reg <= last_speed_reg;
        end
    end

    assign status.out_free   = !m_tvalid_reg || m_tready;
    assign m_tvalid          = m_tvalid_reg;
    assign setpoint_position = out_pos_reg;
    assign setpoint_speed    = out_spd_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.out_load && m_tvalid_reg && !m_tready))
        else $error("output register loaded while its result was stalled");

    a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.limit |=> (hi_reg >= lo_reg))
        else $error("upper speed bound fell below lower bound");

    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.select |=> (last_speed_reg != {1'b1, {(SPD_OUT_W-1){1'b0}}}))
        else $error("applied speed outside its range");
`endif

endmodule

// ===== hdl/trapezoidal_position_ramp.sv =====
// Trapezoidal position ramp: one ramped set point per control tick.
// Input stream s_*: one request per tick carrying the target position.
// Output stream m_*: the new set point and the speed applied in that tick.
// Configuration: cfg_we with cfg_index selects speed_limit_pos (0), speed_limit_neg (1),
// accel_limit_pos (2) or accel_limit_neg (3); write only while no request is in flight.
// Each request goes through two multiplies, a sum, a 25-step bit-serial square
// root for the braking curve, a clamp step and a select step; its write step then
// loads the result into the output register once the output is free.
// A new request is taken only after the previous one has left its write step.
// s_tready is high only while the sequencer is idle; the next request can be
// taken while the previous result still waits in the output register.
// A stalled receiver holds the result in the output register; a following
// request then waits in its last step until that result is taken.
// Reset clears the limits, the kept position and speed, and the output valid.
`timescale 1ns / 1ps

module trapezoidal_position_ramp
    import tpr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] target_position
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] setpoint_position, [48:32] setpoint_speed
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [LIM_W-1:0]       cfg_data
);

    tpr_cmd_t                cmd;
    tpr_status_t             status;
    logic [POS_W-1:0]        setpoint_position;
    logic [SPD_OUT_W-1:0]    setpoint_speed;

    tpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tpr_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .target_position   (s_tdata[POS_W-1:0]),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .setpoint_position (setpoint_position),
        .setpoint_speed    (setpoint_speed)
    );

    assign m_tdata = {{(OUT_TDATA_W-POS_W-SPD_OUT_W){1'b0}}, setpoint_speed, setpoint_position};

endmodule
